### rtl/bdps_pkg.sv
// Package for the bounded deque with pairwise swap.
// Holds sizes, operation and status codes, sequencer states and the store request type.
// No dependencies.
`default_nettype none

package bdps_pkg;

   localparam int DEPTH       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int WORD_W      = 32;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   // number of words a read-out may give at most
   localparam int RD_LIMIT    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_ALL   = 3'd4,
      OP_SWAP       = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP_WAIT,
      S_RD_WAIT,
      S_SW_RB,
      S_SW_WA,
      S_SW_WB,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

   // ring slot of position pos from head; head + pos stays below 2 * DEPTH
   function automatic logic [IDX_W-1:0] slot_wrap(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W+1-IDX_W){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

### rtl/bounded_deque_pair_swap_unit.sv
// Bounded deque of signed words with pairwise swap, top level.
// Depends on bdps_pkg and bdps_store.
`default_nettype none

// Usage
//   req channel: one operation word (req_operation, req_value) per handshake.
//   rsp channel: result words (rsp_result_value, rsp_status, rsp_last); every
//   operation gives one word, except read-out which gives one per held entry,
//   front first, with rsp_last on the final one. Codes six and seven give none.
//   req_ready is high only while the sequencer is idle; one operation at a time.
//   Pushes, pops, empty cases and short swaps go from accept through the
//   decode state, then the pop wait or emit state, into the output register.
//   Read-out issues its first store read in decode, then streams one word per
//   cycle into the output register while rsp is free.
//   Swap walks the pairs through the entry store: keep the first, read the
//   second, write it to the first slot, then the first to the second slot.
//   The store has one read and one write port; that port sets the swap pace.
//   The result sits in an output register, so a stall on rsp holds that word
//   and the sequencer waits; the next operation is taken once the final word
//   of the current one is in the output register.
//   Reset (synchronous, active high) empties the deque; store contents stay
//   undefined until written and are never read before that.

module bounded_deque_pair_swap_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire        [bdps_pkg::OP_W-1:0]      req_operation,
   input  wire signed [bdps_pkg::WORD_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [bdps_pkg::WORD_W-1:0]   rsp_result_value,
   output logic       [bdps_pkg::STATUS_W-1:0]  rsp_status,
   output logic                                 rsp_last
);
   import bdps_pkg::*;

   // control state
   state_type          state_ff,  state_in;
   logic [IDX_W-1:0]   head_ff,   head_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [CNT_W-1:0]   idx_ff,    idx_in;

   // operation and scratch
   logic [OP_W-1:0]    op_ff,     op_in;
   logic [WORD_W-1:0]  value_ff,  value_in;
   logic [WORD_W-1:0]  tmp_ff,    tmp_in;
   logic [WORD_W-1:0]  res_value_ff,  res_value_in;
   status_type         res_status_ff, res_status_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   mem_req_type        mem_req;
   logic [WORD_W-1:0]  rd_data;

   logic [CNT_W-1:0]   rd_pos, wr_pos;
   logic [IDX_W-1:0]   rd_slot, wr_slot;
   logic [IDX_W-1:0]   head_dec, head_inc;
   logic               full, empty, out_free, rd_last;
   logic               load_rsp;
   logic [WORD_W-1:0]  load_value;
   status_type         load_status;
   logic               load_last;

   bdps_store u_store (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   assign rd_slot  = slot_wrap(head_ff, rd_pos);
   assign wr_slot  = slot_wrap(head_ff, wr_pos);
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_last  = ((idx_ff + 1'b1) == count_ff) || ((idx_ff + 1'b1) == CNT_W'(RD_LIMIT));

   assign req_ready = (state_ff == S_IDLE) && !reset;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      tmp_in        = tmp_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rd_pos        = idx_ff;
      wr_pos        = idx_ff;
      mem_req       = '0;
      load_rsp      = 1'b0;
      load_value    = '0;
      load_status   = ST_OK;
      load_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               value_in = req_value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_value_in  = '0;
            res_status_in = ST_OK;
            state_in      = S_EMIT;
            case (op_ff)
               OP_PUSH_BACK: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_pos          = count_ff;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = wr_slot;
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + 1'b1;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = head_dec;
                     mem_req.wr_data = value_ff;
                     head_in         = head_dec;
                     count_in        = count_ff + 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     head_in         = head_inc;
                     count_in        = count_ff - 1'b1;
                     state_in        = S_POP_WAIT;
                  end
               end
               OP_POP_BACK: begin
                  if (empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_pos          = count_ff - 1'b1;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = rd_slot;
                     count_in        = count_ff - 1'b1;
                     state_in        = S_POP_WAIT;
                  end
               end
               OP_READ_ALL: begin
                  if (empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     idx_in          = '0;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     state_in        = S_RD_WAIT;
                  end
               end
               OP_SWAP: begin
                  // fewer than two entries: nothing moves
                  if (count_ff >= CNT_W'(2)) begin
                     idx_in          = '0;
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                     state_in        = S_SW_RB;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_POP_WAIT: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               load_value = rd_data;
               state_in   = S_IDLE;
            end
         end
         S_RD_WAIT: begin
            if (out_free) begin
               load_rsp   = 1'b1;
               load_value = rd_data;
               load_last  = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in          = idx_ff + 1'b1;
                  rd_pos          = idx_ff + 1'b1;
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = rd_slot;
               end
            end
         end
         S_SW_RB: begin
            // first of the pair arrives; fetch the second
            tmp_in          = rd_data;
            rd_pos          = idx_ff + 1'b1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rd_slot;
            state_in        = S_SW_WA;
         end
         S_SW_WA: begin
            wr_pos          = idx_ff;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_slot;
            mem_req.wr_data = rd_data;
            state_in        = S_SW_WB;
         end
         S_SW_WB: begin
            wr_pos          = idx_ff + 1'b1;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_slot;
            mem_req.wr_data = tmp_ff;
            // another full pair left: fetch its first entry now
            if (({1'b0, idx_ff} + (CNT_W+1)'(3)) < {1'b0, count_ff}) begin
               idx_in          = idx_ff + CNT_W'(2);
               rd_pos          = idx_ff + CNT_W'(2);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_slot;
               state_in        = S_SW_RB;
            end else begin
               res_value_in  = '0;
               res_status_in = ST_OK;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               load_value  = res_value_ff;
               load_status = res_status_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = load_value;
         rsp_status_in = load_status;
         rsp_last_in   = load_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      tmp_ff        <= tmp_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/bdps_store.sv
// Entry store of the deque: one write port, one read port with registered data.
// Depends on bdps_pkg.
`default_nettype none

module bdps_store (
   input  wire                           clock,
   input  bdps_pkg::mem_req_type         mem_req,
   output logic [bdps_pkg::WORD_W-1:0]   rd_data_ff
);
   import bdps_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/bdps_checker.sv
// Port-level checks for the deque unit, bound to the top level.
// Depends on bdps_pkg and bounded_deque_pair_swap_unit.
`default_nettype none

module bdps_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_ready,
   input wire        [bdps_pkg::OP_W-1:0]      req_operation,
   input wire signed [bdps_pkg::WORD_W-1:0]    req_value,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire signed [bdps_pkg::WORD_W-1:0]    rsp_result_value,
   input wire        [bdps_pkg::STATUS_W-1:0]  rsp_status,
   input wire                                  rsp_last
);
   import bdps_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // one operation at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // a read-out word that is not the last keeps the input closed
   a_stream_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input opened inside a read-out");

   // error words stand alone and carry zero
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL)
         |-> rsp_last && (rsp_result_value == '0))
      else $error("bad error word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EMPTY
         || rsp_status == ST_FULL))
      else $error("undefined status code");

   logic unused_ok;
   assign unused_ok = ^{req_operation, req_value};

endmodule

bind bounded_deque_pair_swap_unit bdps_checker u_bdps_checker (.*);

`default_nettype wire
